FILE: src/otm_pkg.sv
// ----------------------------------------------------------------------------
// otm_pkg
// Shared types, constants and the Gaussian score table of the onset tempo
// estimator.
// ----------------------------------------------------------------------------
package otm_pkg;

  localparam int unsigned POS_W       = 40;
  localparam int unsigned TEMPO_W     = 15;
  localparam int unsigned CONF_W      = 16;
  localparam int unsigned SPB_W       = 20;
  localparam int unsigned SR_W        = 18;
  localparam int unsigned RATE_W      = 17;
  localparam int unsigned HSIZE_W     = 6;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 18;

  localparam logic [TEMPO_W-1:0] TEMPO_RESET = 15'd7680;
  localparam logic [5:0]         TEMPO_STEP  = 6'd32;
  localparam int unsigned        MIN_ONSETS  = 4;

  // beat numerator 3840 * sample_rate, 30 bits; beat period in Q16 samples
  localparam int unsigned BNUM_W   = 30;
  localparam int unsigned PER_W    = 46;

  // shared divider geometry
  localparam int unsigned DIV_NW   = 62;
  localparam int unsigned DIV_DW   = 46;

  // score table: entry k ~ 65536 * exp(-8k / EXP_DEPTH)
  localparam int unsigned EXP_DEPTH = 256;
  localparam int unsigned EXP_AW    = 8;
  localparam int unsigned EXP_W     = 17;
  // k = floor(xq^2 * 625 * EXP_DEPTH / (9 << 36))
  localparam int unsigned MUL_K     = 625 * EXP_DEPTH;
  localparam int unsigned MUL_K_W   = 18;
  localparam int unsigned K_LIM     = 9 * EXP_DEPTH;
  localparam int unsigned RECIP9    = 7282;

  // Q30 Taylor sum for exp(-8 / EXP_DEPTH), each term truncated
  localparam longint unsigned EXP_TA  = (64'd1 << 33) / EXP_DEPTH;
  localparam longint unsigned EXP_T0  = 64'd1 << 30;
  localparam longint unsigned EXP_T1  = (EXP_T0 * EXP_TA) >> 30;
  localparam longint unsigned EXP_T2  = ((EXP_T1 * EXP_TA) >> 30) / 2;
  localparam longint unsigned EXP_T3  = ((EXP_T2 * EXP_TA) >> 30) / 3;
  localparam longint unsigned EXP_T4  = ((EXP_T3 * EXP_TA) >> 30) / 4;
  localparam longint unsigned EXP_T5  = ((EXP_T4 * EXP_TA) >> 30) / 5;
  localparam longint unsigned EXP_T6  = ((EXP_T5 * EXP_TA) >> 30) / 6;
  localparam longint unsigned EXP_T7  = ((EXP_T6 * EXP_TA) >> 30) / 7;
  localparam longint unsigned EXP_T8  = ((EXP_T7 * EXP_TA) >> 30) / 8;
  localparam longint unsigned EXP_T9  = ((EXP_T8 * EXP_TA) >> 30) / 9;
  localparam longint unsigned EXP_T10 = ((EXP_T9 * EXP_TA) >> 30) / 10;
  localparam longint unsigned EXP_T11 = ((EXP_T10 * EXP_TA) >> 30) / 11;
  localparam longint unsigned EXP_T12 = ((EXP_T11 * EXP_TA) >> 30) / 12;
  localparam longint EXP_SUM = longint'(EXP_T0) - longint'(EXP_T1) + longint'(EXP_T2)
                             - longint'(EXP_T3) + longint'(EXP_T4) - longint'(EXP_T5)
                             + longint'(EXP_T6) - longint'(EXP_T7) + longint'(EXP_T8)
                             - longint'(EXP_T9) + longint'(EXP_T10) - longint'(EXP_T11)
                             + longint'(EXP_T12);
  localparam longint unsigned EXP_C = (EXP_SUM > 0) ? unsigned'(EXP_SUM) : 64'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_RATE  = 3'd0,
    REG_MIN_TEMPO    = 3'd1,
    REG_MAX_TEMPO    = 3'd2,
    REG_ADAPT_RATE   = 3'd3,
    REG_HISTORY_SIZE = 3'd4
  } otm_reg_t;

  typedef enum logic [0:0] {
    REQ_ONSET = 1'b0,
    REQ_CLEAR = 1'b1
  } otm_req_t;

  typedef enum logic [4:0] {
    S_IDLE, S_T_CHK, S_P_GO, S_P_W, S_RD_A, S_RD_B, S_IV, S_Q_GO, S_Q_W,
    S_X_GO, S_X_W, S_SQ, S_N, S_ACC, S_CAND, S_SM1, S_SM2, S_C_GO, S_C_W,
    S_SPB_GO, S_SPB_W, S_OUT
  } otm_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } otm_div_stat_t;

  typedef logic [EXP_W-1:0] otm_exp_tab_t [EXP_DEPTH];

  function automatic otm_exp_tab_t build_exp_tab();
    otm_exp_tab_t tab;
    longint unsigned acc;
    acc = 64'd1 << 30;
    for (int k = 0; k < EXP_DEPTH; k++) begin
      tab[k] = EXP_W'((acc + 64'd8192) >> 14);
      acc = (acc * EXP_C) >> 30;
    end
    return tab;
  endfunction

  localparam otm_exp_tab_t EXP_TAB = build_exp_tab();

endpackage

FILE: src/otm_ram.sv
// ----------------------------------------------------------------------------
// otm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module otm_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/otm_div.sv
// ----------------------------------------------------------------------------
// otm_div
// Restoring divider over a DIV_NW-bit numerator, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module otm_div
  import otm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_NW-1:0]  num,
  input  logic [DIV_DW-1:0]  den,
  output logic [DIV_NW-1:0]  quo,
  output logic [DIV_DW-1:0]  rem,
  output otm_div_stat_t      stat
);

  localparam int unsigned CNT_W = $clog2(DIV_NW + 1);

  logic [DIV_DW-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic [DIV_DW:0]   shifted;
  logic              fits;

  assign shifted = {rem, quo[DIV_NW-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= !start && stat.busy && (cnt == CNT_W'(1));
      if (start) begin
        quo       <= num;
        rem       <= '0;
        dvs       <= den;
        cnt       <= CNT_W'(DIV_NW);
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        // shift in the next numerator bit, subtract when it fits
        if (fits) begin
          rem <= DIV_DW'(shifted - {1'b0, dvs});
        end else begin
          rem <= shifted[DIV_DW-1:0];
        end
        quo <= {quo[DIV_NW-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          stat.busy <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: src/onset_tempo_estimator.sv
// ----------------------------------------------------------------------------
// onset_tempo_estimator
// Inter-onset-interval tempo estimator: onset window in RAM, tempo sweep
// scored with a Gaussian table, smoothed tempo, confidence, samples per beat.
// ----------------------------------------------------------------------------
// A clear, or an onset with fewer than four onsets in the window, goes
//   straight to one division for samples per beat.
// An onset with a fuller window sweeps the candidate tempos on the shared
//   divider (one division per candidate beat period, two per interval), then
//   divides for confidence if a candidate was found, and for samples per beat.
// One item at a time; a finished result waits in the output register while
//   the next item is taken. Reset clears control state and restores 120 BPM;
//   the onset RAM is not cleared, only entries written since a clear are read.
// ----------------------------------------------------------------------------
module onset_tempo_estimator
  import otm_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  req_type,
  input  logic [POS_W-1:0]      onset_position,
  // result items
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TEMPO_W-1:0]    tempo_bpm_q6,
  output logic [CONF_W-1:0]     confidence_q16,
  output logic [SPB_W-1:0]      samples_per_beat,
  output logic                  estimate_updated
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned HX = (CW > HSIZE_W) ? CW : HSIZE_W;
  localparam int unsigned SW = CW + EXP_W;

  // configuration registers
  logic [SR_W-1:0]    sample_rate;
  logic [TEMPO_W-1:0] min_tempo_q6;
  logic [TEMPO_W-1:0] max_tempo_q6;
  logic [RATE_W-1:0]  adaptation_rate_q16;
  logic [HSIZE_W-1:0] history_size;

  // estimator state
  otm_state_t         state, state_next;
  logic [CW-1:0]      onset_count;
  logic [AW-1:0]      write_index;
  logic [AW-1:0]      head;
  logic [TEMPO_W-1:0] smoothed_tempo;
  logic [CONF_W-1:0]  confidence_level;
  logic [SPB_W-1:0]   spb;
  logic               updated;

  // sweep registers
  logic [TEMPO_W:0]   cand_t;
  logic [PER_W-1:0]   period;
  logic [CW-1:0]      ni;
  logic [CW-1:0]      jcnt;
  logic [AW-1:0]      ptr;
  logic [POS_W-1:0]   pos_a;
  logic [POS_W-1:0]   ival;
  logic [PER_W-1:0]   err;
  logic [16:0]        xq;
  logic [33:0]        sq;
  logic [51:0]        nprod;
  logic [SW-1:0]      sum;
  logic [SW-1:0]      best_sum;
  logic [TEMPO_W-1:0] best_t;
  logic               found;
  logic [31:0]        prod1;

  // ram and divider hookup
  logic               ram_we;
  logic [AW-1:0]      ram_raddr;
  logic [POS_W-1:0]   ram_rdata;
  logic               div_start;
  logic [DIV_NW-1:0]  div_num;
  logic [DIV_DW-1:0]  div_den;
  logic [DIV_NW-1:0]  div_quo;
  logic [DIV_DW-1:0]  div_rem;
  otm_div_stat_t      div_stat;

  // combinational helpers
  logic               accept;
  logic [BNUM_W-1:0]  bnum;
  logic [HX-1:0]      hs_x;
  logic [HX-1:0]      h_x;
  logic [CW-1:0]      h;
  logic [CW-1:0]      cnt_clamp;
  logic [CW-1:0]      cnt_new;
  logic [AW-1:0]      ptr_dec;
  logic [AW-1:0]      wi_inc;
  logic [CW-1:0]      jcnt_inc;
  logic [RATE_W-1:0]  rate_sat;
  logic [RATE_W-1:0]  rate_inv;
  logic [32:0]        smooth_sum;
  logic [DIV_DW:0]    twice_rem;
  logic [PER_W-1:0]   err_val;
  logic [15:0]        k_hi;
  logic [28:0]        k_full;
  logic [EXP_W-1:0]   score;
  logic [TEMPO_W:0]   t_inc;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  // 3840 * sample_rate = (sr << 12) - (sr << 8)
  assign bnum = (BNUM_W'(sample_rate) << 12) - (BNUM_W'(sample_rate) << 8);

  // effective window length
  assign hs_x      = HX'(history_size);
  assign h_x       = (hs_x > HX'(HISTORY_DEPTH)) ? HX'(HISTORY_DEPTH) : hs_x;
  assign h         = h_x[CW-1:0];
  assign cnt_clamp = (onset_count > h) ? h : onset_count;
  assign cnt_new   = (cnt_clamp < h) ? cnt_clamp + 1'b1 : cnt_clamp;

  assign ptr_dec  = (ptr == '0) ? AW'(HISTORY_DEPTH - 1) : ptr - 1'b1;
  assign wi_inc   = (write_index == AW'(HISTORY_DEPTH - 1)) ? '0 : write_index + 1'b1;
  assign jcnt_inc = jcnt + 1'b1;
  assign t_inc    = cand_t + (TEMPO_W + 1)'(TEMPO_STEP);

  assign rate_sat   = (adaptation_rate_q16 > 17'd65536) ? 17'd65536 : adaptation_rate_q16;
  assign rate_inv   = 17'd65536 - rate_sat;
  assign smooth_sum = 33'(prod1) + 33'(best_t) * 33'(rate_sat) + 33'd32768;

  // distance to the nearest whole multiple of the period (at least one)
  assign twice_rem = {div_rem, 1'b0};
  assign err_val   = ((twice_rem >= {1'b0, period}) || (div_quo == '0))
                     ? period - div_rem : div_rem;

  // table index: floor((n >> 36) / 9), only looked up while in range
  assign k_hi   = nprod[51:36];
  assign k_full = 29'(k_hi) * 29'(RECIP9);
  assign score  = (k_hi < 16'(K_LIM)) ? EXP_TAB[k_full[16 +: EXP_AW]] : '0;

  assign ram_we = accept && (req_type == REQ_ONSET);

  otm_ram #(
    .WIDTH (POS_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_index),
    .wdata (onset_position),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  otm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .rem   (div_rem),
    .stat  (div_stat)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate         <= 18'd48000;
      min_tempo_q6        <= 15'd3840;
      max_tempo_q6        <= 15'd12800;
      adaptation_rate_q16 <= 17'd6554;
      history_size        <= 6'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAMPLE_RATE:  sample_rate         <= cfg_data;
        REG_MIN_TEMPO:    min_tempo_q6        <= cfg_data[TEMPO_W-1:0];
        REG_MAX_TEMPO:    max_tempo_q6        <= cfg_data[TEMPO_W-1:0];
        REG_ADAPT_RATE:   adaptation_rate_q16 <= cfg_data[RATE_W-1:0];
        REG_HISTORY_SIZE: history_size        <= cfg_data[HSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // next state, divider operands and RAM read address
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    ram_raddr  = ptr;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if ((req_type == REQ_ONSET) && (cnt_new >= CW'(MIN_ONSETS))) begin
            state_next = S_T_CHK;
          end else begin
            state_next = S_SPB_GO;
          end
        end
      end
      S_T_CHK: begin
        if (cand_t > {1'b0, max_tempo_q6}) begin
          state_next = found ? S_SM1 : S_SPB_GO;
        end else if (cand_t != '0) begin
          state_next = S_P_GO;
        end
      end
      S_P_GO: begin
        div_start  = 1'b1;
        div_num    = DIV_NW'({bnum, 16'd0});
        div_den    = DIV_DW'(cand_t);
        state_next = S_P_W;
      end
      S_P_W: begin
        if (div_stat.done) begin
          state_next = (div_quo[PER_W-1:0] == '0) ? S_T_CHK : S_RD_A;
        end
      end
      S_RD_A:  state_next = S_RD_B;
      S_RD_B: begin
        ram_raddr  = ptr_dec;
        state_next = S_IV;
      end
      S_IV:    state_next = S_Q_GO;
      S_Q_GO: begin
        div_start  = 1'b1;
        div_num    = DIV_NW'({ival, 16'd0});
        div_den    = period;
        state_next = S_Q_W;
      end
      S_Q_W:   if (div_stat.done) state_next = S_X_GO;
      S_X_GO: begin
        div_start  = 1'b1;
        div_num    = {err, 16'd0};
        div_den    = period;
        state_next = S_X_W;
      end
      S_X_W:   if (div_stat.done) state_next = S_SQ;
      S_SQ:    state_next = S_N;
      S_N:     state_next = S_ACC;
      S_ACC:   state_next = (jcnt_inc == ni) ? S_CAND : S_RD_A;
      S_CAND:  state_next = S_T_CHK;
      S_SM1:   state_next = S_SM2;
      S_SM2:   state_next = S_C_GO;
      S_C_GO: begin
        div_start  = 1'b1;
        div_num    = DIV_NW'(best_sum);
        div_den    = DIV_DW'(ni);
        state_next = S_C_W;
      end
      S_C_W:   if (div_stat.done) state_next = S_SPB_GO;
      S_SPB_GO: begin
        if (smoothed_tempo == '0) begin
          state_next = S_OUT;
        end else begin
          div_start  = 1'b1;
          div_num    = DIV_NW'(bnum);
          div_den    = DIV_DW'(smoothed_tempo);
          state_next = S_SPB_W;
        end
      end
      S_SPB_W: if (div_stat.done) state_next = S_OUT;
      S_OUT:   if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control state and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      onset_count      <= '0;
      write_index      <= '0;
      smoothed_tempo   <= TEMPO_RESET;
      confidence_level <= '0;
      found            <= 1'b0;
      updated          <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one replaces it
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            updated <= 1'b0;
            found   <= 1'b0;
            cand_t  <= {1'b0, min_tempo_q6};
            if (req_type == REQ_CLEAR) begin
              onset_count      <= '0;
              write_index      <= '0;
              smoothed_tempo   <= TEMPO_RESET;
              confidence_level <= '0;
            end else begin
              // store the onset, advance the ring, remember the newest slot
              onset_count <= cnt_new;
              write_index <= wi_inc;
              head        <= write_index;
              ni          <= cnt_new - 1'b1;
            end
          end
        end
        S_T_CHK: begin
          // skip a zero candidate tempo
          if ((cand_t <= {1'b0, max_tempo_q6}) && (cand_t == '0)) begin
            cand_t <= t_inc;
          end
        end
        S_P_W: begin
          if (div_stat.done) begin
            period <= div_quo[PER_W-1:0];
            sum    <= '0;
            jcnt   <= '0;
            ptr    <= head;
            if (div_quo[PER_W-1:0] == '0) begin
              cand_t <= t_inc;
            end
          end
        end
        S_RD_B: pos_a <= ram_rdata;
        S_IV: begin
          ival <= pos_a - ram_rdata;
          ptr  <= ptr_dec;
        end
        S_Q_W:  if (div_stat.done) err <= err_val;
        S_X_W:  if (div_stat.done) xq <= div_quo[16:0];
        S_SQ:   sq <= xq * xq;
        S_N:    nprod <= sq * MUL_K_W'(MUL_K);
        S_ACC: begin
          sum  <= sum + SW'(score);
          jcnt <= jcnt_inc;
        end
        S_CAND: begin
          // first best score wins
          if (!found || (sum > best_sum)) begin
            found    <= 1'b1;
            best_sum <= sum;
            best_t   <= cand_t[TEMPO_W-1:0];
          end
          cand_t <= t_inc;
        end
        S_SM1:  prod1 <= smoothed_tempo * rate_inv;
        S_SM2: begin
          smoothed_tempo <= smooth_sum[16 +: TEMPO_W];
          updated        <= 1'b1;
        end
        S_C_W: begin
          if (div_stat.done) begin
            confidence_level <= (div_quo[DIV_NW-1:CONF_W] != '0) ? '1
                                : div_quo[CONF_W-1:0];
          end
        end
        S_SPB_GO: if (smoothed_tempo == '0) spb <= '0;
        S_SPB_W: begin
          if (div_stat.done) begin
            spb <= (div_quo[DIV_NW-1:SPB_W] != '0) ? '1 : div_quo[SPB_W-1:0];
          end
        end
        S_OUT: begin
          // load the result once the output register is free
          if (!out_valid || !out_stall) begin
            out_valid        <= 1'b1;
            tempo_bpm_q6     <= smoothed_tempo;
            confidence_q16   <= confidence_level;
            samples_per_beat <= spb;
            estimate_updated <= updated;
          end
        end
        default: ;
      endcase
    end
  end

  // an accepted item always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("accepted item did not start");

  // the shared divider is never restarted mid-division
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // smoothing only follows a sweep that found a candidate
  a_smooth_found: assert property (@(posedge clk) disable iff (rst)
    (state == S_SM1) |-> (found && (onset_count >= CW'(MIN_ONSETS))))
    else $error("smoothing without estimate");

  // interval counter stays inside the window
  a_jcnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC) |-> (jcnt < ni))
    else $error("interval index out of window");

endmodule

FILE: tb/tb_onset_tempo_estimator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_onset_tempo_estimator
// Self-checking bench for the onset tempo estimator. A clocked driver feeds
// onset and clear items from a queue, and a clocked monitor checks every
// result item field by field against a bit-exact tempo predictor kept here.
// The bench runs a directed part (extreme settings and special cases), then
// random phases of beat trains with noise and clears. Both sides idle at
// random.
// ----------------------------------------------------------------------------
module tb_onset_tempo_estimator;
  import otm_pkg::*;

  localparam int unsigned WIN_DEPTH = 32;
  localparam longint unsigned POS_MASK = 64'hFF_FFFF_FFFF;

  typedef struct {
    logic             req;
    logic [POS_W-1:0] pos;
  } onset_item_t;

  typedef struct {
    logic [TEMPO_W-1:0] tempo;
    logic [CONF_W-1:0]  conf;
    logic [SPB_W-1:0]   spb;
    logic               upd;
  } tempo_est_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic                  req_type  = 1'b0;
  logic [POS_W-1:0]      onset_position = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [TEMPO_W-1:0]    tempo_bpm_q6;
  logic [CONF_W-1:0]     confidence_q16;
  logic [SPB_W-1:0]      samples_per_beat;
  logic                  estimate_updated;

  onset_tempo_estimator u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .req_type         (req_type),
    .onset_position   (onset_position),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .tempo_bpm_q6     (tempo_bpm_q6),
    .confidence_q16   (confidence_q16),
    .samples_per_beat (samples_per_beat),
    .estimate_updated (estimate_updated)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Run limit: report failure and stop if the sequence never finishes.
  initial begin
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tempo predictor: own copy of settings, onset window and estimate.
  // --------------------------------------------------------------------------
  longint unsigned gauss_tab [256];
  longint unsigned sr_m, tmin_m, tmax_m, rate_m, hsize_m;
  longint unsigned win_pos [WIN_DEPTH];
  int unsigned     win_cnt, win_wr;
  longint unsigned tempo_m, conf_m;

  onset_item_t pending_q [$];
  tempo_est_t  estimate_q [$];
  int unsigned errors = 0;
  bit          no_idle = 1'b0;
  longint unsigned cur_pos;

  // Gaussian table: Q30 Taylor constant for exp(-8/256), then a recursion.
  task automatic fill_gauss_tab();
    longint unsigned a, term, c, acc;
    longint          sum;
    a    = (64'd1 << 33) / 256;
    term = 64'd1 << 30;
    sum  = 64'sd1 << 30;
    acc  = 64'd1 << 30;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * a) >> 30) / n;
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    c = (sum > 0) ? longint'(sum) : 0;
    for (int k = 0; k < 256; k++) begin
      gauss_tab[k] = (acc + 8192) >> 14;
      acc = (acc * c) >> 30;
    end
  endtask

  function automatic longint unsigned interval_score(longint unsigned d, longint unsigned p);
    longint unsigned dq, m, mp, e, xq, k;
    dq = d << 16;
    m  = (2 * dq + p) / (2 * p);
    if (m == 0) m = 1;
    mp = m * p;
    e  = (dq >= mp) ? dq - mp : mp - dq;
    xq = (e << 16) / p;
    k  = (xq * xq * 256 * 625) / (64'd144 << 32);
    return (k < 256) ? gauss_tab[k] : 0;
  endfunction

  task automatic predict_tempo(input onset_item_t it, output tempo_est_t est);
    longint unsigned iv [WIN_DEPTH];
    longint unsigned p, s, best_sum, best_t, a, c, v;
    int unsigned     h, ni;
    bit              found;
    est.upd = 1'b0;
    if (it.req == REQ_CLEAR) begin
      win_cnt = 0;
      win_wr  = 0;
      tempo_m = TEMPO_RESET;
      conf_m  = 0;
    end else begin
      h = (hsize_m > WIN_DEPTH) ? WIN_DEPTH : hsize_m;
      if (win_cnt > h) win_cnt = h;
      win_pos[win_wr] = it.pos;
      win_wr = (win_wr + 1) % WIN_DEPTH;
      if (win_cnt < h) win_cnt++;
      if (win_cnt >= MIN_ONSETS) begin
        ni = win_cnt - 1;
        for (int j = 0; j < ni; j++)
          iv[j] = (win_pos[(win_wr + 2*WIN_DEPTH - 1 - j) % WIN_DEPTH]
                 - win_pos[(win_wr + 2*WIN_DEPTH - 2 - j) % WIN_DEPTH]) & POS_MASK;
        found = 1'b0;
        best_sum = 0;
        best_t = 0;
        for (longint unsigned t = tmin_m; t <= tmax_m; t += TEMPO_STEP) begin
          if (t == 0) continue;
          p = ((64'd3840 * sr_m) << 16) / t;
          if (p == 0) continue;
          s = 0;
          for (int j = 0; j < ni; j++) s += interval_score(iv[j], p);
          if (!found || s > best_sum) begin
            found = 1'b1;
            best_sum = s;
            best_t = t;
          end
        end
        if (found) begin
          a = (rate_m > 65536) ? 65536 : rate_m;
          tempo_m = ((tempo_m * (65536 - a) + best_t * a + 32768) >> 16) & 16'h7FFF;
          c = best_sum / ni;
          conf_m = (c > 65535) ? 65535 : c;
          est.upd = 1'b1;
        end
      end
    end
    if (tempo_m == 0) v = 0;
    else v = (64'd3840 * sr_m) / tempo_m;
    est.tempo = tempo_m[TEMPO_W-1:0];
    est.conf  = conf_m[CONF_W-1:0];
    est.spb   = (v > 64'hFFFFF) ? 20'hFFFFF : v[SPB_W-1:0];
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present items from the queue, predict each one as it is accepted.
  // --------------------------------------------------------------------------
  int unsigned in_gap = 0;
  always @(posedge clk) begin
    onset_item_t it;
    tempo_est_t  est;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        it.req = req_type;
        it.pos = onset_position;
        predict_tempo(it, est);
        estimate_q = {estimate_q, est};
      end
      // hold the payload while stalled
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          it = pending_q.pop_front();
          req_type <= it.req;
          onset_position <= it.pos;
          in_valid <= 1'b1;
          in_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random back-pressure, compare each accepted result item.
  // --------------------------------------------------------------------------
  int unsigned out_gap = 0;
  always @(posedge clk) begin
    tempo_est_t est;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (estimate_q.size() == 0) begin
          $display("%0t: unexpected result item tempo %0d", $time, tempo_bpm_q6);
          errors++;
        end else begin
          est = estimate_q.pop_front();
          if (tempo_bpm_q6 !== est.tempo) begin
            $display("%0t: tempo_bpm_q6 expected %0d actual %0d",
                     $time, est.tempo, tempo_bpm_q6);
            errors++;
          end
          if (confidence_q16 !== est.conf) begin
            $display("%0t: confidence_q16 expected %0d actual %0d",
                     $time, est.conf, confidence_q16);
            errors++;
          end
          if (samples_per_beat !== est.spb) begin
            $display("%0t: samples_per_beat expected %0d actual %0d",
                     $time, est.spb, samples_per_beat);
            errors++;
          end
          if (estimate_updated !== est.upd) begin
            $display("%0t: estimate_updated expected %0d actual %0d",
                     $time, est.upd, estimate_updated);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        out_gap <= pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Wait until the block has drained, then let it settle before a write.
  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid || estimate_q.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input otm_reg_t idx, input longint unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    case (idx)
      REG_SAMPLE_RATE:  sr_m    = val & 18'h3FFFF;
      REG_MIN_TEMPO:    tmin_m  = val & 15'h7FFF;
      REG_MAX_TEMPO:    tmax_m  = val & 15'h7FFF;
      REG_ADAPT_RATE:   rate_m  = val & 17'h1FFFF;
      REG_HISTORY_SIZE: hsize_m = val & 6'h3F;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(input longint unsigned sr, input longint unsigned tmin,
                         input longint unsigned tmax, input longint unsigned rate,
                         input longint unsigned hs);
    wait_drained();
    write_reg(REG_SAMPLE_RATE, sr);
    write_reg(REG_MIN_TEMPO, tmin);
    write_reg(REG_MAX_TEMPO, tmax);
    write_reg(REG_ADAPT_RATE, rate);
    write_reg(REG_HISTORY_SIZE, hs);
  endtask

  task automatic push_item(input logic req, input longint unsigned pos);
    onset_item_t it;
    it.req = req;
    it.pos = pos[POS_W-1:0];
    pending_q = {pending_q, it};
  endtask

  // Beat train near tempo tq6 with jitter; some noise onsets and clears.
  task automatic push_beats(input int n, input longint unsigned tq6,
                            input int noise_pct);
    longint unsigned period, jit;
    int r;
    period = (tq6 == 0) ? 1000 : (64'd3840 * sr_m) / tq6;
    if (period == 0) period = 1;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < noise_pct / 3) begin
        push_item(REQ_CLEAR, {$urandom, $urandom});
      end else if (r < noise_pct) begin
        push_item(REQ_ONSET, {$urandom, $urandom});
      end else begin
        jit = period / 16 + 1;
        cur_pos = (cur_pos + period + $urandom_range(0, 2 * jit) - jit) & POS_MASK;
        push_item(REQ_ONSET, cur_pos);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    longint unsigned sr, tmin, span, hs, rate;
    int r;
    fill_gauss_tab();
    sr_m = 48000; tmin_m = 3840; tmax_m = 12800; rate_m = 6554; hsize_m = 16;
    win_cnt = 0; win_wr = 0; tempo_m = TEMPO_RESET; conf_m = 0;
    for (int i = 0; i < WIN_DEPTH; i++) win_pos[i] = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: narrow sweep around 120 BPM, full adaptation, window of four.
    no_idle = 1'b1;
    set_all(48000, 7680 - 64, 7680 + 64, 65536, 4);
    push_item(REQ_CLEAR, 0);
    push_item(REQ_ONSET, 0);              // fewer than four onsets
    push_item(REQ_ONSET, 24000);
    push_item(REQ_ONSET, 48000);
    push_item(REQ_ONSET, 72000);          // first estimate
    push_item(REQ_ONSET, POS_MASK);       // interval wraps backwards
    push_item(REQ_ONSET, 23999);          // wrap modulo 2^40
    push_item(REQ_CLEAR, POS_MASK);       // clear restores 120 BPM
    push_item(REQ_ONSET, 100);

    // Widest sweep once, lowest sample rate, tiny window.
    set_all(8000, 1280, 30720, 32768, 4);
    push_item(REQ_CLEAR, 0);
    for (int i = 0; i < 4; i++) push_item(REQ_ONSET, 64'd9_999_000_000 + i * 7500);

    // Empty sweep (min above max), rate above full, window above depth.
    no_idle = 1'b0;
    set_all(192000, 30720, 1280, 131071, 63);
    for (int i = 0; i < 5; i++) push_item(REQ_ONSET, i * 64'd96000);

    // Zero sample rate skips every candidate; window below four.
    set_all(0, 32704, 32767, 0, 3);
    for (int i = 0; i < 3; i++) push_item(REQ_ONSET, i * 1000);
    wait_drained();
    write_reg(REG_HISTORY_SIZE, 5);
    push_item(REQ_ONSET, 3000);
    push_item(REQ_ONSET, 4000);

    // Top sample rate, very slow tempo: samples per beat saturates.
    set_all(262143, 32, 96, 65536, 4);
    push_item(REQ_CLEAR, 0);
    cur_pos = 64'hFF_FFF0_0000;
    push_beats(5, 64, 0);

    // Random phases: mostly beat trains with small windows and few candidates.
    for (int ph = 0; ph < 8; ph++) begin
      r = $urandom_range(0, 9);
      sr   = (r == 0) ? 192000 : $urandom_range(8000, 192000);
      tmin = $urandom_range(1280, 30000);
      span = $urandom_range(0, 6) * TEMPO_STEP;
      rate = (r == 1) ? 65536 : $urandom_range(0, 65536);
      hs   = (r == 2) ? 32 : (r == 3) ? 12 : $urandom_range(4, 8);
      no_idle = (ph == 3);
      set_all(sr, tmin, tmin + span, rate, hs);
      cur_pos = {$urandom, $urandom} & POS_MASK;
      push_beats(9, tmin + $urandom_range(0, span), 20);
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0 && estimate_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
src/otm_pkg.sv
src/otm_ram.sv
src/otm_div.sv
src/onset_tempo_estimator.sv
tb/tb_onset_tempo_estimator.sv
